// ===== src/leb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// leb_pkg: shared types and constants of the line edit buffer
// Line depth, derived widths, command and status codes, and the control
// item broadcast to the row of character cells.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
    localparam int READ_W     = 6;
    localparam int CHAR_W     = 8;
    localparam int POS_W      = 7;
    localparam int CMP_W      = (IDX_W > READ_W) ? IDX_W : READ_W;
    localparam int LEN_CMP_W  = (CNT_W > READ_W) ? CNT_W : READ_W;

    typedef enum logic [2:0] {
        CMD_INSERT    = 3'd0,
        CMD_BACKSPACE = 3'd1,
        CMD_DELETE    = 3'd2,
        CMD_LEFT      = 3'd3,
        CMD_RIGHT     = 3'd4,
        CMD_READ      = 3'd5,
        CMD_CLEAR     = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_BOUND = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Edit broadcast to every cell: open a gap or close one at pos
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [CNT_W-1:0]  pos;
        logic [CHAR_W-1:0] chr;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== src/leb_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// leb_cell: one character cell of the line
// Holds one byte; on an insert at or before its place it takes the byte of
// its left neighbour (or the new byte), on a removal it takes its right
// neighbour's byte. Drives its byte onto the read bus when addressed.
// ----------------------------------------------------------------------------
module leb_cell (
    input  wire logic                          i_clk,
    input  wire logic [leb_pkg::IDX_W-1:0]     i_index,
    input  wire leb_pkg::t_cell_ctl            i_ctl,
    input  wire logic [leb_pkg::CHAR_W-1:0]    i_left,
    input  wire logic [leb_pkg::CHAR_W-1:0]    i_right,
    input  wire logic [leb_pkg::READ_W-1:0]    i_read_idx,
    output logic      [leb_pkg::CHAR_W-1:0]    o_byte,
    output logic      [leb_pkg::CHAR_W-1:0]    o_read
);
    import leb_pkg::*;

    logic [CHAR_W-1:0] r_byte;
    logic [CHAR_W-1:0] n_byte;
    logic [CNT_W-1:0]  w_index;

    assign w_index = CNT_W'(i_index);

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.ins) begin
            if (w_index == i_ctl.pos) begin
                n_byte = i_ctl.chr;
            end else if (w_index > i_ctl.pos) begin
                n_byte = i_left;
            end
        end else if (i_ctl.rem && (w_index >= i_ctl.pos)) begin
            n_byte = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;
    assign o_read = (CMP_W'(i_read_idx) == CMP_W'(i_index)) ? r_byte : '0;

endmodule
`default_nettype wire

// ===== src/leb_cell_row.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// leb_cell_row: the row of character cells
// Chains LINE_DEPTH cells to their neighbours and merges their read outputs
// into one byte.
// ----------------------------------------------------------------------------
module leb_cell_row (
    input  wire logic                          i_clk,
    input  wire leb_pkg::t_cell_ctl            i_ctl,
    input  wire logic [leb_pkg::READ_W-1:0]    i_read_idx,
    output logic      [leb_pkg::CHAR_W-1:0]    o_read_byte
);
    import leb_pkg::*;

    logic [CHAR_W-1:0] w_byte [LINE_DEPTH];
    logic [CHAR_W-1:0] w_read [LINE_DEPTH];

    for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
        logic [CHAR_W-1:0] w_left;
        logic [CHAR_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_byte[g-1];
        end

        if (g == LINE_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_byte[g+1];
        end

        leb_cell u_cell (
            .i_clk      (i_clk),
            .i_index    (IDX_W'(g)),
            .i_ctl      (i_ctl),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_read_idx (i_read_idx),
            .o_byte     (w_byte[g]),
            .o_read     (w_read[g])
        );
    end

    // At most one cell is addressed, so OR the read outputs together
    always_comb begin
        o_read_byte = '0;
        for (int k = 0; k < LINE_DEPTH; k++) begin
            o_read_byte = o_read_byte | w_read[k];
        end
    end

endmodule
`default_nettype wire

// ===== src/line_edit_buffer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// line_edit_buffer: one line of text with a cursor and a length
// Edits or reads the line one command at a time in a row of byte cells.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (i_in_valid / o_in_ready) carries a command, a byte for
//   insert and an index for read. Output channel (o_out_valid / i_out_ready)
//   carries status, cursor, line length and the byte read.
//   Every command gives exactly one result, registered in the cycle after the
//   item is taken. One item per cycle while results are taken: every cell
//   compares its place with the cursor and shifts in the same cycle, so
//   insert and removal cost no more than a cursor move.
//   A new item is taken while the result register is empty or being
//   emptied; while the receiver stalls, the result holds and input stops.
//   Reset (synchronous, active low) empties the line, puts the cursor at 0
//   and drops any pending result. The cell contents are not reset: bytes
//   beyond the length are never returned.
//   Insert into a full line gives status full; a move or removal past either
//   end gives status bound; neither changes the line.
// ----------------------------------------------------------------------------
module line_edit_buffer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [2:0]                    i_command,
    input  wire logic [leb_pkg::CHAR_W-1:0]    i_character,
    input  wire logic [leb_pkg::READ_W-1:0]    i_read_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [1:0]                    o_status,
    output logic      [leb_pkg::POS_W-1:0]     o_cursor,
    output logic      [leb_pkg::POS_W-1:0]     o_line_length,
    output logic      [leb_pkg::CHAR_W-1:0]    o_read_byte
);
    import leb_pkg::*;

    logic              r_out_valid;
    logic [CNT_W-1:0]  r_cursor;
    logic [CNT_W-1:0]  r_length;
    logic [CNT_W-1:0]  n_cursor;
    logic [CNT_W-1:0]  n_length;
    t_status           r_status;
    t_status           n_status;
    logic [CHAR_W-1:0] r_read_byte;
    logic [CHAR_W-1:0] n_read_byte;
    logic [CHAR_W-1:0] w_row_byte;
    logic              w_accept;
    logic              w_in_line;
    t_cell_ctl         w_ctl;
    t_cmd              w_cmd;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cmd      = t_cmd'(i_command);
    assign w_in_line  = LEN_CMP_W'(i_read_index) < LEN_CMP_W'(r_length);

    always_comb begin
        n_cursor    = r_cursor;
        n_length    = r_length;
        n_status    = ST_DONE;
        n_read_byte = '0;
        w_ctl.ins   = 1'b0;
        w_ctl.rem   = 1'b0;
        w_ctl.pos   = r_cursor;
        w_ctl.chr   = i_character;
        case (w_cmd)
            CMD_INSERT: begin
                if (r_length >= CNT_W'(LINE_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.ins = 1'b1;
                    n_cursor  = r_cursor + 1'b1;
                    n_length  = r_length + 1'b1;
                end
            end
            CMD_BACKSPACE: begin
                if (r_cursor == '0) begin
                    n_status = ST_BOUND;
                end else begin
                    w_ctl.rem = 1'b1;
                    w_ctl.pos = r_cursor - 1'b1;
                    n_cursor  = r_cursor - 1'b1;
                    n_length  = r_length - 1'b1;
                end
            end
            CMD_DELETE: begin
                if (r_cursor >= r_length) begin
                    n_status = ST_BOUND;
                end else begin
                    w_ctl.rem = 1'b1;
                    n_length  = r_length - 1'b1;
                end
            end
            CMD_LEFT: begin
                if (r_cursor == '0) begin
                    n_status = ST_BOUND;
                end else begin
                    n_cursor = r_cursor - 1'b1;
                end
            end
            CMD_RIGHT: begin
                if (r_cursor >= r_length) begin
                    n_status = ST_BOUND;
                end else begin
                    n_cursor = r_cursor + 1'b1;
                end
            end
            CMD_READ: begin
                if (w_in_line) begin
                    n_read_byte = w_row_byte;
                end
            end
            CMD_CLEAR: begin
                n_cursor = '0;
                n_length = '0;
            end
            default: begin
                n_status = ST_BOUND;
            end
        endcase
        // Leave the cells alone unless the item is actually taken
        if (!w_accept) begin
            w_ctl.ins = 1'b0;
            w_ctl.rem = 1'b0;
        end
    end

    leb_cell_row u_row (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_read_idx  (i_read_index),
        .o_read_byte (w_row_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cursor    <= '0;
            r_length    <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_cursor    <= n_cursor;
                r_length    <= n_length;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_read_byte <= n_read_byte;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_cursor      = POS_W'(r_cursor);
    assign o_line_length = POS_W'(r_length);
    assign o_read_byte   = r_read_byte;

endmodule
`default_nettype wire

// ===== src/leb_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// leb_checker: port-level checks of the line edit buffer
// Watches the top level's ports and flags broken results or handshakes.
// ----------------------------------------------------------------------------
module leb_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_ready,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [1:0]                    o_status,
    input  wire logic [leb_pkg::POS_W-1:0]     o_cursor,
    input  wire logic [leb_pkg::POS_W-1:0]     o_line_length,
    input  wire logic [leb_pkg::CHAR_W-1:0]    o_read_byte
);
    import leb_pkg::*;

    // A taken item always yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("no result after an accepted item");

    // A stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_cursor) && $stable(o_line_length) && $stable(o_read_byte))
        else $error("stalled result changed");

    // Cursor never passes the end of the line
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cursor <= o_line_length)
        else $error("cursor beyond line length");

    // Full status only when the line is full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |->
            32'(o_line_length) == (LINE_DEPTH % (1 << POS_W)))
        else $error("full status on a line that is not full");

    // A byte comes back only with a completed command
    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_byte != '0) |-> o_status == ST_DONE)
        else $error("read byte with a failing status");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_cursor      (o_cursor),
    .o_line_length (o_line_length),
    .o_read_byte   (o_read_byte)
);
`default_nettype wire

// ===== dv/line_edit_buffer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_buffer_tb: self-checking bench for the line edit buffer
// Drives edit and read commands through the valid/ready input, mirrors the
// line, cursor and length in a scoreboard and checks every result in order.
// A directed opening covers the bounds, then a fill to a full line, then
// random runs biased towards growing, shrinking, mixing or walking the line.
// ----------------------------------------------------------------------------
module line_edit_buffer_tb;
    import leb_pkg::*;

    localparam logic [2:0] CMD_UNUSED = 3'd7;

    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIX    = 2;
    localparam int MODE_WALK   = 3;

    localparam int RANDOM_ITEMS = 355;
    localparam int LONG_HOLD    = 40;

    typedef struct {
        t_status            status;
        logic [POS_W-1:0]   cursor;
        logic [POS_W-1:0]   length;
        logic [CHAR_W-1:0]  read_byte;
    } t_edit_result;

    class edit_scoreboard;
        logic [CHAR_W-1:0] text [LINE_DEPTH];
        int unsigned       cur;
        int unsigned       len;
        t_edit_result      result_q [$];
        int                errors;

        function new();
            cur    = 0;
            len    = 0;
            errors = 0;
            foreach (text[i]) text[i] = '0;
        endfunction

        // Close the gap left by the byte at position at
        function void remove_at(int unsigned at);
            for (int unsigned i = at; i + 1 < len; i++) text[i] = text[i + 1];
            len--;
        endfunction

        function void note_command(logic [2:0] cmd, logic [CHAR_W-1:0] chr,
                                   logic [READ_W-1:0] idx);
            t_edit_result r;
            r.status    = ST_DONE;
            r.read_byte = '0;
            case (cmd)
                CMD_INSERT: begin
                    if (len >= LINE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int unsigned i = len; i > cur; i--) text[i] = text[i - 1];
                        text[cur] = chr;
                        cur++;
                        len++;
                    end
                end
                CMD_BACKSPACE: begin
                    if (cur == 0) begin
                        r.status = ST_BOUND;
                    end else begin
                        cur--;
                        remove_at(cur);
                    end
                end
                CMD_DELETE: begin
                    if (cur >= len) r.status = ST_BOUND;
                    else remove_at(cur);
                end
                CMD_LEFT: begin
                    if (cur == 0) r.status = ST_BOUND;
                    else cur--;
                end
                CMD_RIGHT: begin
                    if (cur >= len) r.status = ST_BOUND;
                    else cur++;
                end
                CMD_READ: begin
                    if (idx < len) r.read_byte = text[idx];
                end
                CMD_CLEAR: begin
                    cur = 0;
                    len = 0;
                end
                default: begin
                    r.status = ST_BOUND;
                end
            endcase
            r.cursor = cur[POS_W-1:0];
            r.length = len[POS_W-1:0];
            result_q.push_back(r);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] status, logic [POS_W-1:0] cursor,
                                   logic [POS_W-1:0] length,
                                   logic [CHAR_W-1:0] read_byte);
            t_edit_result w;
            if (result_q.size() == 0) begin
                $display({"%0t ns: result with nothing outstanding: expected none, ",
                          "actual %0d %0d %0d %0d"},
                         $time, status, cursor, length, read_byte);
                errors++;
                return;
            end
            w = result_q.pop_front();
            compare_field("status", 8'(w.status), 8'(status));
            compare_field("cursor", 8'(w.cursor), 8'(cursor));
            compare_field("line_length", 8'(w.length), 8'(length));
            compare_field("read_byte", w.read_byte, read_byte);
        endfunction

        function int pending();
            return result_q.size();
        endfunction
    endclass

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic [2:0]          i_command    = '0;
    logic [CHAR_W-1:0]   i_character  = '0;
    logic [READ_W-1:0]   i_read_index = '0;
    logic                i_out_ready  = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [1:0]          o_status;
    logic [POS_W-1:0]    o_cursor;
    logic [POS_W-1:0]    o_line_length;
    logic [CHAR_W-1:0]   o_read_byte;

    edit_scoreboard sb = new();

    int burst_left    = 0;
    bit long_hold_req = 1'b0;
    int hold_left     = 0;
    int phase_left    = 0;
    int stall_pct     = 0;

    line_edit_buffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_character   (i_character),
        .i_read_index  (i_read_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_cursor      (o_cursor),
        .o_line_length (o_line_length),
        .o_read_byte   (o_read_byte)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: phases of varying stall rate, plus one long hold on request
    always @(posedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
        end
        if (phase_left == 0) begin
            phase_left = $urandom_range(16, 80);
            case ($urandom_range(0, 4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 20;
                3:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end
        phase_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_status, o_cursor, o_line_length, o_read_byte);
    end

    function automatic logic [CHAR_W-1:0] any_chr();
        return CHAR_W'($urandom);
    endfunction

    function automatic logic [READ_W-1:0] any_idx();
        return READ_W'($urandom);
    endfunction

    // Offer one item and hold it until taken; gaps fall between bursts
    task automatic send_item(logic [2:0] cmd, logic [CHAR_W-1:0] chr,
                             logic [READ_W-1:0] idx);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_character  <= chr;
        i_read_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_command(cmd, chr, idx);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [2:0] pick_command(int mode);
        int         w [8];
        int         r;
        int         acc;
        logic [2:0] codes [8];
        codes = '{CMD_INSERT, CMD_BACKSPACE, CMD_DELETE, CMD_LEFT,
                  CMD_RIGHT, CMD_READ, CMD_CLEAR, CMD_UNUSED};
        case (mode)
            MODE_GROW:   w = '{65, 7, 6, 6, 6, 7, 1, 2};
            MODE_SHRINK: w = '{15, 30, 25, 10, 6, 10, 2, 2};
            MODE_MIX:    w = '{30, 12, 12, 12, 12, 18, 3, 1};
            default:     w = '{10, 5, 5, 25, 25, 28, 1, 1};
        endcase
        r   = $urandom_range(0, 99);
        acc = 0;
        for (int i = 0; i < 8; i++) begin
            acc += w[i];
            if (r < acc) return codes[i];
        end
        return CMD_READ;
    endfunction

    task automatic send_random(int mode);
        logic [CHAR_W-1:0] chr;
        logic [READ_W-1:0] idx;
        case ($urandom_range(0, 9))
            0:       chr = 8'h00;
            1:       chr = 8'hFF;
            default: chr = CHAR_W'($urandom_range(0, 255));
        endcase
        // Bias reads towards stored bytes
        if (sb.len > 0 && $urandom_range(0, 1))
            idx = READ_W'($urandom_range(0, sb.len - 1));
        else
            idx = READ_W'($urandom_range(0, 63));
        send_item(pick_command(mode), chr, idx);
    endtask

    initial begin
        int sent;
        bit hold_done;
        bit drain_done;
        int seg;
        int mode;

        sent       = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bounds on an empty line, unused code, byte extremes, mid-line edits
        send_item(CMD_BACKSPACE, any_chr(), any_idx());
        send_item(CMD_LEFT, any_chr(), any_idx());
        send_item(CMD_DELETE, any_chr(), any_idx());
        send_item(CMD_RIGHT, any_chr(), any_idx());
        send_item(CMD_READ, any_chr(), 6'd0);
        send_item(CMD_UNUSED, any_chr(), any_idx());
        send_item(CMD_INSERT, 8'h00, any_idx());
        send_item(CMD_INSERT, 8'hFF, any_idx());
        send_item(CMD_INSERT, 8'h80, any_idx());
        send_item(CMD_LEFT, any_chr(), any_idx());
        send_item(CMD_LEFT, any_chr(), any_idx());
        send_item(CMD_INSERT, 8'h7F, any_idx());
        send_item(CMD_READ, any_chr(), 6'd0);
        send_item(CMD_READ, any_chr(), 6'd1);
        send_item(CMD_READ, any_chr(), 6'd3);
        send_item(CMD_READ, any_chr(), 6'd4);
        send_item(CMD_READ, any_chr(), 6'd63);
        send_item(CMD_RIGHT, any_chr(), any_idx());
        send_item(CMD_DELETE, any_chr(), any_idx());
        send_item(CMD_BACKSPACE, any_chr(), any_idx());
        send_item(CMD_CLEAR, any_chr(), any_idx());
        send_item(CMD_READ, any_chr(), 6'd0);

        // Fill the line, then push against the full and end bounds
        while (sb.len < LINE_DEPTH) send_item(CMD_INSERT, any_chr(), any_idx());
        send_item(CMD_INSERT, any_chr(), any_idx());
        send_item(CMD_READ, any_chr(), 6'd63);
        send_item(CMD_READ, any_chr(), 6'd0);
        send_item(CMD_RIGHT, any_chr(), any_idx());
        send_item(CMD_DELETE, any_chr(), any_idx());
        send_item(CMD_LEFT, any_chr(), any_idx());
        send_item(CMD_LEFT, any_chr(), any_idx());
        send_item(CMD_INSERT, any_chr(), any_idx());
        send_item(CMD_BACKSPACE, any_chr(), any_idx());
        send_item(CMD_INSERT, any_chr(), any_idx());

        while (sent < RANDOM_ITEMS) begin
            mode = $urandom_range(MODE_GROW, MODE_WALK);
            seg  = $urandom_range(20, 60);
            for (int k = 0; k < seg && sent < RANDOM_ITEMS; k++) begin
                if (!hold_done && sent >= 200) begin
                    // Stall the receiver and keep offering items back to back
                    hold_done     = 1'b1;
                    long_hold_req = 1'b1;
                    burst_left    = 24;
                end
                if (!drain_done && sent >= 300) begin
                    drain_done = 1'b1;
                    drain();
                end
                send_random(mode);
                sent++;
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/leb_pkg.sv
src/leb_cell.sv
src/leb_cell_row.sv
src/line_edit_buffer.sv
src/leb_checker.sv
dv/line_edit_buffer_tb.sv
